// ===== hdl/rwr_pkg.sv =====
// shared types and constants for the random walk with restart engine
// no dependencies
package rwr_pkg;

	localparam int DEF_MAX_NODES = 64;
	localparam int NODE_LIMIT    = 64;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_SEED  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [2:0] REG_ACTIVE_NODES   = 3'd0;
	localparam logic [2:0] REG_RESTART_WEIGHT = 3'd1;
	localparam logic [2:0] REG_WALK_WEIGHT    = 3'd2;
	localparam logic [2:0] REG_STOP_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_ITERATION_CAP  = 3'd4;

	localparam logic [6:0]  RST_ACTIVE_NODES   = 7'd64;
	localparam logic [15:0] RST_RESTART_WEIGHT = 16'd4915;
	localparam logic [15:0] RST_WALK_WEIGHT    = 16'd27853;
	localparam logic [31:0] RST_STOP_THRESHOLD = 32'd10737;
	localparam logic [15:0] RST_ITERATION_CAP  = 16'd1000;

	localparam logic [6:0] SEED_COUNT_MAX = 7'd127;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  row_index;
		logic [5:0]  col_index;
		logic [15:0] edge_weight;
		logic [5:0]  seed_node;
	} item_t;

	typedef struct packed {
		logic [5:0]  node_index;
		logic [31:0] proximity;
		logic        last_node;
		logic        stop_cause;
		logic [15:0] iterations_used;
	} result_t;

endpackage

// ===== hdl/rwr_div.sv =====
// bit-serial restoring divider: share = floor(2^30 / divisor)
// depends on rwr_pkg
module rwr_div
	import rwr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [6:0]  divisor,
	output logic        done,
	output logic [30:0] quotient
);

	logic [6:0]  rem_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic [7:0]  trial;
	logic        dbit;

	assign dbit  = (step_q == 5'd30);
	assign trial = {rem_q, dbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'd30;
			end else if (busy_q) begin
				if (step_q == 5'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					step_q <= step_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= '0;
			quotient <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q    <= 7'(trial - {1'b0, divisor});
				quotient <= {quotient[29:0], 1'b1};
			end else begin
				rem_q    <= trial[6:0];
				quotient <= {quotient[29:0], 1'b0};
			end
		end
	end

endmodule

// ===== hdl/random_walk_restart_engine.sv =====
// random walk with restart engine, top level
// depends on rwr_pkg and rwr_div
//
// Weight writes and seed marks are accepted in the idle state. A start transaction
// runs the divider for the restart share, loads the restart vector, then per
// iteration works through n rows on one shared 16x32 multiplier (n
// multiply-accumulates, walk and restart terms, write-back) followed by the
// convergence test, and finally reads out one result per node, each held until the
// output side takes it. The block takes no transaction while a run is busy.
module random_walk_restart_engine
	import rwr_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);

	localparam int TOP    = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(TOP + 1);
	localparam int ACC_W  = 48 + $clog2(TOP);
	localparam int DIST_W = 33 + $clog2(TOP);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_LOAD, ST_MAC, ST_ROW_W, ST_ROW_R, ST_ROW_SUM,
		ST_ROW_WR, ST_ITER_END, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
	} state_t;

	state_t state_q;

	logic [6:0]  active_nodes_q;
	logic [15:0] restart_weight_q;
	logic [15:0] walk_weight_q;
	logic [31:0] stop_threshold_q;
	logic [15:0] iteration_cap_q;

	logic [MAX_NODES-1:0] marks_q;
	logic [6:0]           seed_count_q;

	logic [15:0] w_mem [MAX_NODES][MAX_NODES];
	logic [31:0] vec_mem [2][MAX_NODES];
	logic [15:0] w_rd_q;
	logic [31:0] vec_rd_q;

	logic [CNT_W-1:0]  n_q, i_q, j_q;
	logic              sel_q;
	logic              v_s1, v_s2;
	logic [47:0]       prod_s2;
	logic [ACC_W-1:0]  acc_q;
	logic [32:0]       term_q;
	logic [31:0]       next_q;
	logic [DIST_W-1:0] dist_q;
	logic [15:0]       iters_q;
	logic [15:0]       cap_q;
	logic              cause_q;

	logic        div_start, div_done;
	logic [30:0] share;

	logic              accept;
	logic              issue;
	logic              rd_bank;
	logic [NODE_W-1:0] rd_node;
	logic              wr_en;
	logic              wr_bank;
	logic [31:0]       wr_data;
	logic [15:0]       mul_a;
	logic [31:0]       mul_b;
	logic [31:0]       mv;
	logic [33:0]       sum;
	logic [31:0]       absdiff;
	logic              beyond;
	logic              hit;
	logic [31:0]       restart_val;
	logic [CNT_W-1:0]  n_next;
	logic [NODE_W-1:0] seed_idx;
	logic              conv;
	logic [16:0]       iters_inc;

	rwr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (seed_count_q),
		.done     (div_done),
		.quotient (share)
	);

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign div_start  = accept && (item.kind == KIND_START);
	assign res_valid  = (state_q == ST_OUT_WAIT);
	assign issue      = (state_q == ST_MAC) && (j_q < n_q);

	always_comb begin
		if (active_nodes_q == 7'd0)
			n_next = CNT_W'(1);
		else if (32'(active_nodes_q) > TOP)
			n_next = CNT_W'(TOP);
		else
			n_next = CNT_W'(active_nodes_q);
	end

	assign seed_idx = (32'(item.seed_node) < MAX_NODES) ? NODE_W'(item.seed_node) : '0;

	always_comb begin
		beyond = 1'b0;
		for (int g = 0; g < MAX_NODES; g++)
			if (g >= 32'(n_q) && marks_q[g])
				beyond = 1'b1;
	end

	assign hit = marks_q[NODE_W'(i_q)] || ((i_q == '0) && beyond);
	assign restart_val = hit ? {1'b0, share} : 32'd0;

	assign mv = (|acc_q[ACC_W-1:46]) ? 32'hFFFF_FFFF : acc_q[45:14];

	always_comb begin
		case (state_q)
			ST_ROW_W: begin
				mul_a = walk_weight_q;
				mul_b = mv;
			end
			ST_ROW_R: begin
				mul_a = restart_weight_q;
				mul_b = restart_val;
			end
			default: begin
				mul_a = w_rd_q;
				mul_b = vec_rd_q;
			end
		endcase
	end

	assign sum = {1'b0, term_q} + {1'b0, prod_s2[47:15]};
	assign absdiff = (next_q > vec_rd_q) ? (next_q - vec_rd_q) : (vec_rd_q - next_q);
	assign conv = ({{(DIST_W-32){1'b0}}, stop_threshold_q} >= dist_q);
	assign iters_inc = {1'b0, iters_q} + 17'd1;

	always_comb begin
		case (state_q)
			ST_MAC: begin
				rd_bank = sel_q;
				rd_node = NODE_W'(j_q);
			end
			ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT: begin
				rd_bank = ~sel_q;
				rd_node = NODE_W'(i_q);
			end
			default: begin
				rd_bank = sel_q;
				rd_node = NODE_W'(i_q);
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_bank = sel_q;
		wr_data = restart_val;
		case (state_q)
			ST_LOAD: wr_en = 1'b1;
			ST_ROW_WR: begin
				wr_en   = 1'b1;
				wr_bank = ~sel_q;
				wr_data = next_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// weight memory
	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_WRITE && 32'(item.row_index) < MAX_NODES
				&& 32'(item.col_index) < MAX_NODES)
			w_mem[NODE_W'(item.row_index)][NODE_W'(item.col_index)] <= item.edge_weight;
		w_rd_q <= w_mem[NODE_W'(i_q)][NODE_W'(j_q)];
	end

	// ping-pong vector memory
	always_ff @(posedge clk) begin
		if (wr_en)
			vec_mem[wr_bank][NODE_W'(i_q)] <= wr_data;
		vec_rd_q <= vec_mem[rd_bank][rd_node];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 48'(mul_a * mul_b);
		case (state_q)
			ST_ROW_R:   term_q <= prod_s2[47:15];
			ST_ROW_SUM: next_q <= (|sum[33:32]) ? 32'hFFFF_FFFF : sum[31:0];
			ST_OUT_LD: begin
				res.node_index      <= 6'(i_q);
				res.proximity       <= vec_rd_q;
				res.last_node       <= (i_q + CNT_W'(1) == n_q);
				res.stop_cause      <= cause_q;
				res.iterations_used <= iters_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_nodes_q   <= RST_ACTIVE_NODES;
			restart_weight_q <= RST_RESTART_WEIGHT;
			walk_weight_q    <= RST_WALK_WEIGHT;
			stop_threshold_q <= RST_STOP_THRESHOLD;
			iteration_cap_q  <= RST_ITERATION_CAP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_NODES:   active_nodes_q   <= cfg_wdata[6:0];
				REG_RESTART_WEIGHT: restart_weight_q <= cfg_wdata[15:0];
				REG_WALK_WEIGHT:    walk_weight_q    <= cfg_wdata[15:0];
				REG_STOP_THRESHOLD: stop_threshold_q <= cfg_wdata;
				REG_ITERATION_CAP:  iteration_cap_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			marks_q      <= '0;
			seed_count_q <= '0;
			n_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			sel_q        <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			acc_q        <= '0;
			dist_q       <= '0;
			iters_q      <= '0;
			cap_q        <= '0;
			cause_q      <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2)
				acc_q <= acc_q + ACC_W'(prod_s2);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.kind)
							KIND_SEED: begin
								marks_q[seed_idx] <= 1'b1;
								if (seed_count_q < SEED_COUNT_MAX)
									seed_count_q <= seed_count_q + 7'd1;
							end
							KIND_START: begin
								n_q     <= n_next;
								cap_q   <= (iteration_cap_q == 16'd0) ? 16'd1 : iteration_cap_q;
								i_q     <= '0;
								sel_q   <= 1'b0;
								state_q <= ST_DIV;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (i_q + CNT_W'(1) == n_q) begin
						i_q     <= '0;
						j_q     <= '0;
						acc_q   <= '0;
						dist_q  <= '0;
						iters_q <= '0;
						state_q <= ST_MAC;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_MAC: begin
					if (issue)
						j_q <= j_q + CNT_W'(1);
					else if (!v_s1 && !v_s2)
						state_q <= ST_ROW_W;
				end
				ST_ROW_W:   state_q <= ST_ROW_R;
				ST_ROW_R:   state_q <= ST_ROW_SUM;
				ST_ROW_SUM: state_q <= ST_ROW_WR;
				ST_ROW_WR: begin
					dist_q <= dist_q + DIST_W'(absdiff);
					acc_q  <= '0;
					j_q    <= '0;
					if (i_q + CNT_W'(1) == n_q) begin
						state_q <= ST_ITER_END;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_MAC;
					end
				end
				ST_ITER_END: begin
					iters_q <= iters_inc[15:0];
					i_q     <= '0;
					if (conv || iters_inc >= {1'b0, cap_q}) begin
						cause_q <= ~conv;
						state_q <= ST_OUT_RD;
					end else begin
						sel_q   <= ~sel_q;
						dist_q  <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_LD;
				ST_OUT_LD: state_q <= ST_OUT_WAIT;
				ST_OUT_WAIT: begin
					if (res_ready) begin
						if (i_q + CNT_W'(1) == n_q) begin
							marks_q      <= '0;
							seed_count_q <= '0;
							state_q      <= ST_IDLE;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== verif/random_walk_restart_engine_test.sv =====
// self-checking testbench for random_walk_restart_engine
// holds a scoreboard class with a fixed-point power iteration predictor
// depends on rwr_pkg and the engine rtl
`timescale 1ns / 100ps

module random_walk_restart_engine_test;
	import rwr_pkg::*;

	localparam int QUIET_LIMIT = 100000;

	class proximity_scoreboard;
		bit [15:0] weights [4096];
		bit        marks [64];
		int        mark_count;
		bit [6:0]  active_nodes;
		bit [15:0] restart_weight;
		bit [15:0] walk_weight;
		bit [31:0] stop_threshold;
		bit [15:0] iteration_cap;
		bit [31:0] restart_vec [64];
		bit [31:0] prev_vec [64];
		bit [31:0] cur_vec [64];
		result_t   expected_q [$];
		int        errors;

		function new();
			active_nodes   = RST_ACTIVE_NODES;
			restart_weight = RST_RESTART_WEIGHT;
			walk_weight    = RST_WALK_WEIGHT;
			stop_threshold = RST_STOP_THRESHOLD;
			iteration_cap  = RST_ITERATION_CAP;
			mark_count     = 0;
			errors         = 0;
			foreach (marks[i]) marks[i] = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_ACTIVE_NODES:   active_nodes   = val[6:0];
				REG_RESTART_WEIGHT: restart_weight = val[15:0];
				REG_WALK_WEIGHT:    walk_weight    = val[15:0];
				REG_STOP_THRESHOLD: stop_threshold = val;
				REG_ITERATION_CAP:  iteration_cap  = val[15:0];
				default: ;
			endcase
		endfunction

		function int node_count();
			if (active_nodes == 0) return 1;
			if (active_nodes > 64) return 64;
			return active_nodes;
		endfunction

		function bit [31:0] sat32(longint unsigned v);
			return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		endfunction

		function void walk_step(int n);
			longint unsigned acc;
			longint unsigned walk_term;
			longint unsigned rest_term;
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					acc += longint'(weights[i * 64 + j]) * longint'(prev_vec[j]);
				walk_term = (longint'(walk_weight) * longint'(sat32(acc >> 14))) >> 15;
				rest_term = (longint'(restart_weight) * longint'(restart_vec[i])) >> 15;
				cur_vec[i] = sat32(walk_term + rest_term);
			end
		endfunction

		function longint unsigned l1_gap(int n);
			longint unsigned d;
			d = 0;
			for (int i = 0; i < n; i++)
				d += (cur_vec[i] > prev_vec[i]) ? cur_vec[i] - prev_vec[i]
					: prev_vec[i] - cur_vec[i];
			return d;
		endfunction

		function void run_walk();
			int n;
			int cap;
			int iters;
			bit [31:0] share;
			longint unsigned gap;
			result_t r;
			n = node_count();
			share = mark_count ? 32'(64'd1073741824 / mark_count) : 0;
			foreach (restart_vec[i]) restart_vec[i] = 0;
			for (int i = 0; i < 64; i++)
				if (marks[i]) restart_vec[(i < n) ? i : 0] = share;
			prev_vec = restart_vec;
			cap = iteration_cap ? iteration_cap : 1;
			walk_step(n);
			iters = 1;
			gap = l1_gap(n);
			while (gap > stop_threshold && iters < cap) begin
				prev_vec = cur_vec;
				walk_step(n);
				iters++;
				gap = l1_gap(n);
			end
			for (int i = 0; i < n; i++) begin
				r.node_index      = i[5:0];
				r.proximity       = cur_vec[i];
				r.last_node       = (i + 1 == n);
				r.stop_cause      = (gap > stop_threshold);
				r.iterations_used = iters[15:0];
				expected_q.insert(expected_q.size(), r);
			end
			foreach (marks[i]) marks[i] = 0;
			mark_count = 0;
		endfunction

		function void note_item(item_t it);
			case (it.kind)
				KIND_WRITE: weights[{it.row_index, it.col_index}] = it.edge_weight;
				KIND_SEED: begin
					marks[it.seed_node] = 1;
					if (mark_count < SEED_COUNT_MAX) mark_count++;
				end
				KIND_START: run_walk();
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result node_index %0d", got.node_index);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.node_index != want.node_index) begin
				$error("node_index expected %0d actual %0d", want.node_index, got.node_index);
				errors++;
			end
			if (got.proximity != want.proximity) begin
				$error("proximity expected %0h actual %0h", want.proximity, got.proximity);
				errors++;
			end
			if (got.last_node != want.last_node) begin
				$error("last_node expected %0d actual %0d", want.last_node, got.last_node);
				errors++;
			end
			if (got.stop_cause != want.stop_cause) begin
				$error("stop_cause expected %0d actual %0d", want.stop_cause, got.stop_cause);
				errors++;
			end
			if (got.iterations_used != want.iterations_used) begin
				$error("iterations_used expected %0d actual %0d",
					want.iterations_used, got.iterations_used);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        res_valid;
	logic        res_ready;
	result_t     res;

	proximity_scoreboard sb;
	bit written [4096];
	bit calm;
	int quiet_cycles;
	int sent_items;

	random_walk_restart_engine u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function bit idle_now();
		return !calm && ($urandom_range(99) < 37);
	endfunction

	always @(negedge clk) begin
		res_ready <= !idle_now();
	end

	always @(posedge clk) begin
		if (item_valid && item_ready) sb.note_item(item);
		if (res_valid && res_ready) sb.check_result(res);
		if ((item_valid && item_ready) || (res_valid && res_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL random_walk_restart_engine");
			$finish;
		end
	end

	task automatic send(logic [1:0] kind, int row, int col, int w, int seed);
		item_t it;
		it.kind        = kind;
		it.row_index   = row[5:0];
		it.col_index   = col[5:0];
		it.edge_weight = w[15:0];
		it.seed_node   = seed[5:0];
		while (idle_now()) begin
			item_valid <= 0;
			@(negedge clk);
		end
		item_valid <= 1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		if (kind == KIND_WRITE) written[{it.row_index, it.col_index}] = 1;
		sent_items++;
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic configure(int n, int rw, int ww, logic [31:0] thr, int cap);
		drain();
		cfg_write(REG_ACTIVE_NODES, n);
		cfg_write(REG_RESTART_WEIGHT, rw);
		cfg_write(REG_WALK_WEIGHT, ww);
		cfg_write(REG_STOP_THRESHOLD, thr);
		cfg_write(REG_ITERATION_CAP, cap);
	endtask

	// every entry a run reads must have been written
	task automatic fill_matrix();
		int n;
		n = sb.node_count();
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (!written[i * 64 + j])
					send(KIND_WRITE, i, j, $urandom_range(3) == 0 ? 16'hFFFF
						: $urandom_range(16'h1000), 0);
	endtask

	task automatic random_run();
		int n;
		n = sb.node_count();
		repeat ($urandom_range(6)) begin
			send(KIND_WRITE, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
				$urandom_range(63));
		end
		repeat ($urandom_range(4)) begin
			send(KIND_SEED, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
				$urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(n - 1));
		end
		if ($urandom_range(9) == 0) begin
			send(2'd3, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
				$urandom_range(63));
		end
		fill_matrix();
		send(KIND_START, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
			$urandom_range(63));
	endtask

	initial begin
		int n;
		int phase;
		logic [31:0] thr;
		sb = new();
		arst_n       = 0;
		cfg_we       = 0;
		cfg_index    = 0;
		cfg_wdata    = 0;
		item_valid   = 0;
		item         = '0;
		res_ready    = 0;
		calm         = 0;
		quiet_cycles = 0;
		sent_items   = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed part
		configure(4, 4915, 27853, 10737, 40);
		fill_matrix();
		send(2'd3, 63, 63, 16'hFFFF, 63);
		send(KIND_SEED, 0, 0, 0, 1);
		send(KIND_SEED, 0, 0, 0, 1);
		send(KIND_SEED, 0, 0, 0, 63);
		send(KIND_START, 0, 0, 0, 0);
		send(KIND_START, 0, 0, 0, 0);
		send(KIND_WRITE, 3, 3, 0, 0);
		send(KIND_SEED, 0, 0, 0, 3);
		send(KIND_START, 0, 0, 0, 0);
		configure(0, 32768, 0, 0, 0);
		send(KIND_SEED, 0, 0, 0, 0);
		send(KIND_START, 0, 0, 0, 0);
		configure(8, 32768, 0, 32'hFFFF_FFFF, 65535);
		fill_matrix();
		send(KIND_SEED, 0, 0, 0, 0);
		send(KIND_SEED, 0, 0, 0, 63);
		send(KIND_START, 0, 0, 0, 0);
		configure(8, 4915, 27853, 0, 2);
		send(KIND_SEED, 0, 0, 0, 5);
		send(KIND_START, 0, 0, 0, 0);

		// random part
		phase = 0;
		while (sent_items < 230) begin
			phase++;
			calm = (phase >= 2 && phase <= 3);
			n = ($urandom_range(5) == 0) ? $urandom_range(8, 7) : $urandom_range(6, 1);
			case ($urandom_range(3))
				0: thr = 0;
				1: thr = $urandom_range(20000);
				2: thr = $urandom();
				default: thr = 32'h0100_0000;
			endcase
			configure(n,
				$urandom_range(3) == 0 ? 32768 : $urandom_range(32768),
				$urandom_range(3) == 0 ? 32768 : $urandom_range(32768),
				thr, (n > 8) ? $urandom_range(20, 1) : $urandom_range(60, 1));
			repeat ($urandom_range(8, 3)) random_run();
			if (phase % 3 == 0) drain();
		end

		calm = 0;
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("PASS random_walk_restart_engine");
		else
			$display("FAIL random_walk_restart_engine");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/rwr_pkg.sv
hdl/rwr_div.sv
hdl/random_walk_restart_engine.sv
verif/random_walk_restart_engine_test.sv
